/* rtl/obmt_pkg.sv */
// Shared types, constants and codes of the overlapping box merge table.
package obmt_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int CoordW     = 32;
  localparam int MembersW   = 16;
  localparam int AbsorbedW  = 6;

  localparam logic [MembersW-1:0]  MembersMax  = '1;
  localparam logic [AbsorbedW-1:0] AbsorbedMax = '1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DUMP   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DUMP_RD,
    ST_DUMP_LD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_x;
  } box_t;

  typedef struct packed {
    logic [MembersW-1:0] members;
    box_t                box;
  } entry_t;

  typedef struct packed {
    logic overlap;
    box_t merged;
  } cmp_res_t;

  typedef struct packed {
    logic                 last;
    logic                 overflow;
    logic                 entry_valid;
    logic [AbsorbedW-1:0] absorbed;
    logic [MembersW-1:0]  members;
    box_t                 box;
  } result_t;

endpackage

/* rtl/overlapping_box_merge_table.sv */
// Top level of the overlapping box merge table: sequencer, entry memory and output register.
// Insert: after the accept, each entry scanned passes a read and a compare state, and the
//   append is done in the read state; an absorption closes up each later entry with a read
//   and a write state, then rescans from 0. Dump: each entry passes read, load and present.
// Clear and empty dump go from idle straight to the result. The next item is accepted once
// the last result is taken.
// Reset: the sequencer and the entry count clear at once; the entry memory keeps no reset.
module overlapping_box_merge_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request channel.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata, from bit 0 up: box_min_x[31:0], box_min_y[31:0], box_max_x[31:0], box_max_y[31:0].
  input  logic [127:0] s_axis_tdata_i,
  // tuser: req_type[1:0].
  input  logic [1:0]   s_axis_tuser_i,
  // Result channel.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata, from bit 0 up: res_min_x[31:0], res_min_y[31:0], res_max_x[31:0],
  // res_max_y[31:0], members[15:0], absorbed[5:0], two zero pad bits.
  output logic [151:0] m_axis_tdata_o,
  // tuser, from bit 0 up: entry_valid, overflow.
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int CntW = obmt_pkg::CntW;
  localparam int IdxW = obmt_pkg::IdxW;
  localparam logic [CntW-1:0] FullCount = CntW'(obmt_pkg::TableDepth);

  // Sequencer state and its working registers.
  obmt_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  live_q, live_d;     // number of valid entries
  logic [CntW-1:0]  idx_q, idx_d;       // scan or dump position
  logic [CntW-1:0]  sh_q, sh_d;         // close-up position after an absorption
  obmt_pkg::box_t   work_q, work_d;     // working box of the insert
  logic [obmt_pkg::MembersW-1:0]  mem_q, mem_d;
  logic [obmt_pkg::AbsorbedW-1:0] abs_q, abs_d;
  obmt_pkg::result_t out_q, out_d;

  // Entry memory: one write and one registered read per cycle.
  obmt_pkg::entry_t table_mem [obmt_pkg::TableDepth];
  obmt_pkg::entry_t rdata_q;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  obmt_pkg::entry_t wr_data;

  obmt_pkg::cmp_res_t cmp_res;
  obmt_pkg::result_t  zero_res;
  obmt_pkg::entry_t   work_entry;
  logic [obmt_pkg::MembersW:0] mem_sum;
  logic s_fire, m_fire;

  obmt_cmp_unit u_cmp (
    .work_i  (work_q),
    .entry_i (rdata_q.box),
    .res_o   (cmp_res)
  );

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == obmt_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == obmt_pkg::ST_OUT);
  assign m_axis_tdata_o  = {2'b00, out_q.absorbed, out_q.members, out_q.box};
  assign m_axis_tuser_o  = {out_q.overflow, out_q.entry_valid};
  assign m_axis_tlast_o  = out_q.last;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rdata_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obmt_pkg::ST_IDLE;
      live_q  <= '0;
      idx_q   <= '0;
      sh_q    <= '0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      idx_q   <= idx_d;
      sh_q    <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    mem_q  <= mem_d;
    abs_q  <= abs_d;
    out_q  <= out_d;
  end

  always_comb begin
    zero_res             = '0;
    zero_res.last        = 1'b1;
    work_entry.box       = work_q;
    work_entry.members   = mem_q;
    mem_sum              = {1'b0, mem_q} + {1'b0, rdata_q.members};

    state_d = state_q;
    live_d  = live_q;
    idx_d   = idx_q;
    sh_d    = sh_q;
    work_d  = work_q;
    mem_d   = mem_q;
    abs_d   = abs_q;
    out_d   = out_q;
    rd_addr = idx_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = sh_q[IdxW-1:0];
    wr_data = rdata_q;

    case (state_q)
      obmt_pkg::ST_IDLE: begin
        if (s_fire) begin
          work_d = s_axis_tdata_i;
          mem_d  = obmt_pkg::MembersW'(1);
          abs_d  = '0;
          idx_d  = '0;
          case (obmt_pkg::req_e'(s_axis_tuser_i))
            obmt_pkg::REQ_INSERT: state_d = obmt_pkg::ST_SCAN_RD;
            obmt_pkg::REQ_DUMP: begin
              if (live_q == '0) begin
                out_d   = zero_res;
                state_d = obmt_pkg::ST_OUT;
              end else begin
                state_d = obmt_pkg::ST_DUMP_RD;
              end
            end
            obmt_pkg::REQ_CLEAR: begin
              live_d  = '0;
              out_d   = zero_res;
              state_d = obmt_pkg::ST_OUT;
            end
            default: state_d = obmt_pkg::ST_IDLE;  // reserved code: no result
          endcase
        end
      end

      obmt_pkg::ST_SCAN_RD: begin
        if (idx_q == live_q) begin
          // No entry left that overlaps: append the box or report a full table.
          out_d.box         = work_q;
          out_d.members     = mem_q;
          out_d.absorbed    = abs_q;
          out_d.entry_valid = 1'b1;
          out_d.last        = 1'b1;
          if (live_q == FullCount) begin
            out_d.overflow = 1'b1;
          end else begin
            out_d.overflow = 1'b0;
            wr_en          = 1'b1;
            wr_addr        = live_q[IdxW-1:0];
            wr_data        = work_entry;
            live_d         = live_q + CntW'(1);
          end
          state_d = obmt_pkg::ST_OUT;
        end else begin
          state_d = obmt_pkg::ST_SCAN_CMP;
        end
      end

      obmt_pkg::ST_SCAN_CMP: begin
        if (cmp_res.overlap) begin
          work_d  = cmp_res.merged;
          mem_d   = mem_sum[obmt_pkg::MembersW] ? obmt_pkg::MembersMax
                                                : mem_sum[obmt_pkg::MembersW-1:0];
          abs_d   = (abs_q == obmt_pkg::AbsorbedMax) ? abs_q
                                                     : abs_q + obmt_pkg::AbsorbedW'(1);
          sh_d    = idx_q;
          state_d = obmt_pkg::ST_SHIFT_RD;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = obmt_pkg::ST_SCAN_RD;
        end
      end

      obmt_pkg::ST_SHIFT_RD: begin
        // Later entries close up one place; the scan then starts over.
        if (sh_q + CntW'(1) == live_q) begin
          live_d  = live_q - CntW'(1);
          idx_d   = '0;
          state_d = obmt_pkg::ST_SCAN_RD;
        end else begin
          rd_addr = IdxW'(sh_q + CntW'(1));
          state_d = obmt_pkg::ST_SHIFT_WR;
        end
      end

      obmt_pkg::ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh_q[IdxW-1:0];
        wr_data = rdata_q;
        sh_d    = sh_q + CntW'(1);
        state_d = obmt_pkg::ST_SHIFT_RD;
      end

      obmt_pkg::ST_DUMP_RD: begin
        state_d = obmt_pkg::ST_DUMP_LD;
      end

      obmt_pkg::ST_DUMP_LD: begin
        out_d.box         = rdata_q.box;
        out_d.members     = rdata_q.members;
        out_d.absorbed    = '0;
        out_d.entry_valid = 1'b1;
        out_d.overflow    = 1'b0;
        out_d.last        = (idx_q + CntW'(1) == live_q);
        state_d           = obmt_pkg::ST_OUT;
      end

      obmt_pkg::ST_OUT: begin
        if (m_fire) begin
          if (out_q.last) begin
            state_d = obmt_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = obmt_pkg::ST_DUMP_RD;
          end
        end
      end

      default: state_d = obmt_pkg::ST_IDLE;
    endcase
  end

  // The entry count never passes the table depth.
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= FullCount)
    else $error("entry count exceeds table depth");

  // A new request is never taken while a result is still on offer.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("request accepted while a result is pending");

  // A clear empties the table in the next cycle.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser_i == obmt_pkg::REQ_CLEAR) |=> live_q == '0)
    else $error("clear did not empty the table");

  // An overflow result is only reported with a full table.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> live_q == FullCount)
    else $error("overflow reported with room in the table");

endmodule

/* rtl/obmt_cmp_unit.sv */
// Overlap test and min/max union of a working box against one table entry.
module obmt_cmp_unit (
  input  obmt_pkg::box_t     work_i,
  input  obmt_pkg::box_t     entry_i,
  output obmt_pkg::cmp_res_t res_o
);

  logic emin_x_lt, emax_x_lt, emin_x_gt, emax_x_gt;
  logic emin_y_lt, emax_y_lt, emin_y_gt, emax_y_gt;
  logic apart_x, apart_y;

  always_comb begin
    emin_x_lt = entry_i.min_x < work_i.min_x;
    emax_x_lt = entry_i.max_x < work_i.min_x;
    emin_x_gt = entry_i.min_x > work_i.max_x;
    emax_x_gt = entry_i.max_x > work_i.max_x;
    emin_y_lt = entry_i.min_y < work_i.min_y;
    emax_y_lt = entry_i.max_y < work_i.min_y;
    emin_y_gt = entry_i.min_y > work_i.max_y;
    emax_y_gt = entry_i.max_y > work_i.max_y;

    // Touching edges count as overlap, so only strict compares separate.
    apart_x = (emin_x_lt && emax_x_lt) || (emin_x_gt && emax_x_gt);
    apart_y = (emin_y_lt && emax_y_lt) || (emin_y_gt && emax_y_gt);

    res_o.overlap      = !apart_x && !apart_y;
    res_o.merged.min_x = emin_x_lt ? entry_i.min_x : work_i.min_x;
    res_o.merged.min_y = emin_y_lt ? entry_i.min_y : work_i.min_y;
    res_o.merged.max_x = (entry_i.max_x > work_i.max_x) ? entry_i.max_x : work_i.max_x;
    res_o.merged.max_y = emax_y_gt ? entry_i.max_y : work_i.max_y;
  end

endmodule

/* tb/overlapping_box_merge_table_tb.sv */
// Self-checking testbench for the overlapping box merge table: directed, fill and random requests.
`timescale 1ns / 100ps

module overlapping_box_merge_table_tb;

  // The request code that the block accepts and ignores.
  localparam logic [1:0] ReqReserved = 2'd3;

  localparam int IdlePct       = 18;
  localparam int StallLimit    = 20000;
  localparam int DrainCycles   = 100;
  localparam int RandomItems   = 280;
  localparam int HoldOffCycles = 400;
  localparam int MaxReports    = 10;
  localparam int MembersLsb    = 4 * obmt_pkg::CoordW;
  localparam int AbsorbedLsb   = MembersLsb + obmt_pkg::MembersW;

  localparam logic signed [obmt_pkg::CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [obmt_pkg::CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i  = '0;
  logic [1:0]   s_axis_tuser_i  = obmt_pkg::REQ_INSERT;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [151:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  overlapping_box_merge_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Shadow copy of the box table and the results still owed by the block.
  obmt_pkg::entry_t  box_store[$];
  obmt_pkg::result_t pending_results[$];

  bit steady        = 1'b0;
  int hold_requests = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;
  int items_sent;
  int inserts_seen;
  int merges_seen;
  int overflows_seen;
  int dump_rows_seen;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------------

  // On one axis an entry lies apart when both its edges are strictly below the
  // working min edge or both strictly above the working max edge.
  function automatic bit axis_apart(input logic signed [obmt_pkg::CoordW-1:0] emin, emax,
                                    wmin, wmax);
    return (emin < wmin && emax < wmin) || (emin > wmax && emax > wmax);
  endfunction

  function automatic obmt_pkg::result_t make_result(input obmt_pkg::box_t b,
                                                    input int unsigned mem,
                                                    input int unsigned absn, input bit valid,
                                                    input bit ovf, input bit lst);
    obmt_pkg::result_t r;
    r.box         = b;
    r.members     = mem[obmt_pkg::MembersW-1:0];
    r.absorbed    = absn[obmt_pkg::AbsorbedW-1:0];
    r.entry_valid = valid;
    r.overflow    = ovf;
    r.last        = lst;
    return r;
  endfunction

  // Appends one result to the list of those still owed.
  function automatic void expect_result(input obmt_pkg::result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Updates the shadow table for one accepted request and queues its results.
  function automatic void apply_request(input logic [1:0] kind, input obmt_pkg::box_t b);
    obmt_pkg::box_t   work;
    obmt_pkg::entry_t e;
    int unsigned      mem;
    int unsigned      absn;
    int               i;
    case (kind)
      obmt_pkg::REQ_INSERT: begin
        work = b;
        mem  = 1;
        absn = 0;
        i    = 0;
        inserts_seen++;
        // Absorb the first overlapping entry, close the gap and rescan from the start.
        while (i < box_store.size()) begin
          e = box_store[i];
          if (!axis_apart(e.box.min_x, e.box.max_x, work.min_x, work.max_x) &&
              !axis_apart(e.box.min_y, e.box.max_y, work.min_y, work.max_y)) begin
            if (e.box.min_x < work.min_x) work.min_x = e.box.min_x;
            if (e.box.max_x > work.max_x) work.max_x = e.box.max_x;
            if (e.box.min_y < work.min_y) work.min_y = e.box.min_y;
            if (e.box.max_y > work.max_y) work.max_y = e.box.max_y;
            mem = mem + e.members;
            if (mem > obmt_pkg::MembersMax) mem = obmt_pkg::MembersMax;
            if (absn < obmt_pkg::AbsorbedMax) absn++;
            merges_seen++;
            box_store.delete(i);
            i = 0;
          end else begin
            i++;
          end
        end
        if (box_store.size() >= obmt_pkg::TableDepth) begin
          overflows_seen++;
          expect_result(make_result(work, mem, absn, 1'b1, 1'b1, 1'b1));
        end else begin
          e.box     = work;
          e.members = mem[obmt_pkg::MembersW-1:0];
          box_store.insert(box_store.size(), e);
          expect_result(make_result(work, mem, absn, 1'b1, 1'b0, 1'b1));
        end
      end
      obmt_pkg::REQ_DUMP: begin
        if (box_store.size() == 0) begin
          expect_result(make_result('0, 0, 0, 1'b0, 1'b0, 1'b1));
        end else begin
          foreach (box_store[k]) begin
            dump_rows_seen++;
            expect_result(make_result(box_store[k].box, box_store[k].members, 0,
                                      1'b1, 1'b0, k == box_store.size() - 1));
          end
        end
      end
      obmt_pkg::REQ_CLEAR: begin
        box_store.delete();
        expect_result(make_result('0, 0, 0, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        // The reserved code leaves the table alone and answers nothing.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checking, watchdog
  // ---------------------------------------------------------------------------

  // A pending hold-off wins over the random ready pattern.
  always @(posedge clk_i) begin
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  function automatic string describe(input obmt_pkg::result_t r);
    return {$sformatf("box (%0d,%0d)-(%0d,%0d)",
                      r.box.min_x, r.box.min_y, r.box.max_x, r.box.max_y),
            $sformatf(" members %0d absorbed %0d valid %0b ovf %0b last %0b",
                      r.members, r.absorbed, r.entry_valid, r.overflow, r.last)};
  endfunction

  task automatic report_mismatch(input string what, input string want, input string got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t mismatch: %s", $realtime, what);
      $display("  expected %s", want);
      $display("  actual   %s", got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    obmt_pkg::result_t got;
    obmt_pkg::result_t want;
    string             bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.box         = m_axis_tdata_o[MembersLsb-1:0];
      got.members     = m_axis_tdata_o[AbsorbedLsb-1:MembersLsb];
      got.absorbed    = m_axis_tdata_o[AbsorbedLsb+obmt_pkg::AbsorbedW-1:AbsorbedLsb];
      got.entry_valid = m_axis_tuser_o[0];
      got.overflow    = m_axis_tuser_o[1];
      got.last        = m_axis_tlast_o;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", "none", describe(got));
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (got.box.min_x !== want.box.min_x)     bad = {bad, " min_x"};
        if (got.box.min_y !== want.box.min_y)     bad = {bad, " min_y"};
        if (got.box.max_x !== want.box.max_x)     bad = {bad, " max_x"};
        if (got.box.max_y !== want.box.max_y)     bad = {bad, " max_y"};
        if (got.members !== want.members)         bad = {bad, " members"};
        if (got.absorbed !== want.absorbed)       bad = {bad, " absorbed"};
        if (got.entry_valid !== want.entry_valid) bad = {bad, " entry_valid"};
        if (got.overflow !== want.overflow)       bad = {bad, " overflow"};
        if (got.last !== want.last)               bad = {bad, " last"};
        if (bad != "") report_mismatch({"wrong field:", bad}, describe(want), describe(got));
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("No item moved for %0d cycles, %0d results still pending.",
               StallLimit, pending_results.size());
      $display("[overlapping_box_merge_table] ERROR");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge that accepts it. The valid stays
  // high on return, so the caller either sends again or drains right away.
  task automatic send_item(input logic [1:0] kind, input obmt_pkg::box_t b);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_request(kind, b);
    if (kind != ReqReserved) items_sent++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic obmt_pkg::box_t make_box(input int min_x, min_y, max_x, max_y);
    obmt_pkg::box_t b;
    b.min_x = min_x;
    b.min_y = min_y;
    b.max_x = max_x;
    b.max_y = max_y;
    return b;
  endfunction

  function automatic obmt_pkg::box_t random_box();
    return make_box($urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic obmt_pkg::box_t cluster_box(input int base, input int spread,
                                                 input int max_size);
    int x;
    int y;
    x = base + int'($urandom_range(spread));
    y = base + int'($urandom_range(spread));
    return make_box(x, y, x + int'($urandom_range(max_size)), y + int'($urandom_range(max_size)));
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(4))
      0: return CoordMin;
      1: return CoordMax;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int random_base();
    return $signed($urandom_range(32'h7FFF_FFFF)) - 1073741824;
  endfunction

  // Fills the table with exactly TableDepth boxes, one per 1000-wide column so
  // that no two of them overlap.
  task automatic fill_table(input int base);
    int x;
    send_item(obmt_pkg::REQ_CLEAR, random_box());
    for (int k = 0; k < obmt_pkg::TableDepth; k++) begin
      x = base + k * 1000 + int'($urandom_range(400));
      send_item(obmt_pkg::REQ_INSERT, make_box(x, -int'($urandom_range(5000)),
                                               x + int'($urandom_range(500)),
                                               int'($urandom_range(5000))));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_table();
    send_item(obmt_pkg::REQ_DUMP, '0);
    send_item(obmt_pkg::REQ_CLEAR, '0);
    send_item(ReqReserved, random_box());
    send_item(obmt_pkg::REQ_DUMP, random_box());
  endtask

  task automatic test_merge_rules();
    send_item(obmt_pkg::REQ_INSERT, make_box(0, 0, 10, 10));
    // Apart by one unit on x, then apart by one unit on y.
    send_item(obmt_pkg::REQ_INSERT, make_box(11, 0, 20, 10));
    send_item(obmt_pkg::REQ_INSERT, make_box(-5, 11, -1, 15));
    // Touches both of the first two boxes, so the scan absorbs one and restarts.
    send_item(obmt_pkg::REQ_INSERT, make_box(10, 5, 11, 6));
    // A point box just below the third box, then a point on its corner.
    send_item(obmt_pkg::REQ_INSERT, make_box(-1, 10, -1, 10));
    send_item(obmt_pkg::REQ_INSERT, make_box(-1, 11, -1, 11));
    send_item(obmt_pkg::REQ_DUMP, '0);
    // Inverted box: min edges above max edges.
    send_item(obmt_pkg::REQ_INSERT, make_box(100, 100, -100, -100));
    // The widest box swallows every entry.
    send_item(obmt_pkg::REQ_INSERT, make_box(CoordMin, CoordMin, CoordMax, CoordMax));
    send_item(obmt_pkg::REQ_INSERT, make_box(CoordMax, CoordMax, CoordMin, CoordMin));
    send_item(obmt_pkg::REQ_DUMP, '0);
    send_item(obmt_pkg::REQ_CLEAR, make_box(-1, -1, -1, -1));
    send_item(obmt_pkg::REQ_DUMP, '0);
  endtask

  task automatic test_table_full();
    int base;
    base = random_base();
    fill_table(base);
    // Disjoint boxes on a full table are dropped.
    send_item(obmt_pkg::REQ_INSERT, make_box(base + 40000, 0, base + 40500, 10));
    send_item(obmt_pkg::REQ_INSERT, cluster_box(base - 50000, 1000, 100));
    // Absorbing one column entry frees a slot, so this one still fits.
    send_item(obmt_pkg::REQ_INSERT, make_box(base + 5000, 0, base + 5950, 0));
    send_item(obmt_pkg::REQ_DUMP, '0);
    send_item(obmt_pkg::REQ_INSERT, make_box(CoordMin, CoordMin, CoordMax, CoordMax));
    send_item(obmt_pkg::REQ_DUMP, '0);
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // block backs up into its request side.
  task automatic test_backpressure();
    int base;
    base = random_base();
    fill_table(base);
    wait_results_drained();
    hold_requests++;
    send_item(obmt_pkg::REQ_DUMP, '0);
    send_item(obmt_pkg::REQ_INSERT, make_box(base - 2000, 0, base - 1500, 0));
    send_item(obmt_pkg::REQ_DUMP, '0);
    send_item(obmt_pkg::REQ_CLEAR, '0);
    send_item(obmt_pkg::REQ_DUMP, '0);
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    int               base;
    int               n;
    int               sel;
    obmt_pkg::box_t   b;
    obmt_pkg::entry_t e;
    base = random_base();
    n    = 0;
    while (n < RandomItems) begin
      steady = (n >= 120 && n < 180);
      // Now and then the sender waits for every result and moves to a new area.
      if (n % 70 == 69) begin
        wait_results_drained();
        base = random_base();
      end
      sel = $urandom_range(99);
      if (sel < 2) begin
        send_item(ReqReserved, random_box());
        continue;
      end else if (sel < 10) begin
        send_item(obmt_pkg::REQ_DUMP, random_box());
      end else if (sel < 13) begin
        send_item(obmt_pkg::REQ_CLEAR, random_box());
      end else begin
        sel = $urandom_range(99);
        if (sel < 55) begin
          b = cluster_box(base, 4000, 300);
        end else if (sel < 70 && box_store.size() != 0) begin
          // Touches an entry on its right edge, or misses it by one unit.
          e       = box_store[$urandom_range(box_store.size() - 1)];
          b.min_x = e.box.max_x + int'($urandom_range(1));
          b.max_x = b.min_x + int'($urandom_range(200));
          b.min_y = e.box.min_y;
          b.max_y = e.box.max_y;
        end else if (sel < 80) begin
          b = cluster_box(base, 4000, 300);
          b = make_box(b.max_x, b.max_y, b.min_x, b.min_y);
        end else if (sel < 92) begin
          b = random_box();
        end else begin
          b = make_box(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
        end
        send_item(obmt_pkg::REQ_INSERT, b);
      end
      n++;
    end
    steady = 1'b0;
  endtask

  initial begin
    items_sent     = 0;
    inserts_seen   = 0;
    merges_seen    = 0;
    overflows_seen = 0;
    dump_rows_seen = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_merge_rules();
    test_table_full();
    test_backpressure();
    test_random_mix();

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests: %0d inserts, %0d entries absorbed, %0d dropped as overflow.",
             items_sent, inserts_seen, merges_seen, overflows_seen);
    $display("Dumps returned %0d table entries; %0d mismatches counted.",
             dump_rows_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[overlapping_box_merge_table] OK");
    end else begin
      $display("[overlapping_box_merge_table] ERROR");
    end
    $finish;
  end

endmodule
